>>> hdl/se3_projection_jacobian_unit_macros.svh
// Assertion macros for the SE(3) projection Jacobian unit.
`ifndef SE3_PROJECTION_JACOBIAN_UNIT_MACROS_SVH
`define SE3_PROJECTION_JACOBIAN_UNIT_MACROS_SVH

// same-cycle implication
`define SE3PJ_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("se3pj assertion failed");

// next-cycle implication
`define SE3PJ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("se3pj assertion failed");

`endif

>>> hdl/se3pj_pkg.sv
// Shared types and constants of the SE(3) projection Jacobian unit.
package se3pj_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned PT_W = 32;
  localparam int unsigned FOC_W = 28;
  localparam int unsigned ENT_W = 40;
  localparam int unsigned Q_W = ENT_W;
  localparam int unsigned SQ_W = 2 * PT_W - 1;
  localparam int unsigned DEN_W = 2 * PT_W - 2;
  localparam int unsigned REM_W = DEN_W + Q_W;
  localparam int unsigned PRD_W = FOC_W + PT_W;
  localparam int unsigned N_LANE = 10;
  localparam int unsigned FRONT_LAT = 4;
  localparam int unsigned LANE_LAT = Q_W + 3;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y = 2'd1;
  localparam logic [FOC_W-1:0] FOCAL_RST = 28'h200_0000;

  localparam int unsigned LN_U_TX = 0;
  localparam int unsigned LN_U_TZ = 1;
  localparam int unsigned LN_U_RX = 2;
  localparam int unsigned LN_U_RY = 3;
  localparam int unsigned LN_U_RZ = 4;
  localparam int unsigned LN_V_TY = 5;
  localparam int unsigned LN_V_TZ = 6;
  localparam int unsigned LN_V_RX = 7;
  localparam int unsigned LN_V_RY = 8;
  localparam int unsigned LN_V_RZ = 9;

  typedef struct packed {
    logic act;
    logic pos;
  } flag_t;

  typedef struct packed {
    logic [REM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic [FOC_W-1:0] add;
    logic             neg;
  } lane_in_t;

  typedef struct packed {
    logic             ok;
    logic             neg;
    logic             sat;
    logic [FOC_W-1:0] add;
    logic [REM_W-1:0] ds;
    logic [REM_W-1:0] rem;
    logic [Q_W-1:0]   quo;
  } div_word_t;

  function automatic logic [PT_W-1:0] abs_pt(logic [PT_W-1:0] v);
    return v[PT_W-1] ? (~v + 1'b1) : v;
  endfunction

endpackage

>>> hdl/se3pj_front.sv
// Front end: sign split, products and per-entry numerator/denominator.
module se3pj_front #(
  parameter int unsigned FRAC_BITS = se3pj_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 act_i,
  input  logic signed [se3pj_pkg::PT_W-1:0]    point_x_i,
  input  logic signed [se3pj_pkg::PT_W-1:0]    point_y_i,
  input  logic signed [se3pj_pkg::PT_W-1:0]    point_z_i,
  input  logic [se3pj_pkg::FOC_W-1:0]          focal_x_i,
  input  logic [se3pj_pkg::FOC_W-1:0]          focal_y_i,
  output se3pj_pkg::flag_t                     flag_o,
  output se3pj_pkg::lane_in_t                  lane_o [se3pj_pkg::N_LANE]
);
  import se3pj_pkg::*;

  flag_t f1_q, f2_q, f3_q, f4_q;
  logic [PT_W-1:0] ax_q, ay_q, az_q, az2_q, az3_q;
  logic nx1_q, ny1_q, nx2_q, ny2_q, nx3_q, ny3_q;

  logic [2*PT_W-1:0] z2_full, xx_full, yy_full, xy_full;
  logic [PRD_W-1:0] fxax_w, fxay_w, fyay_w, fyax_w;
  logic [DEN_W-1:0] z2_q, z23_q;
  logic [SQ_W-1:0] xx_q, yy_q, xy_q;
  logic [PRD_W-1:0] fxax_q, fxay_q, fyay_q, fyax_q;
  logic [PRD_W-1:0] fxax3_q, fxay3_q, fyay3_q, fyax3_q;

  logic [SQ_W-1:0] sq_sel [4];
  logic [FOC_W-1:0] fc_sel [4];
  logic [PRD_W-1:0] plo_d [4];
  logic [PRD_W-2:0] phi_d [4];
  logic [PRD_W-1:0] plo_q [4];
  logic [PRD_W-2:0] phi_q [4];
  logic [REM_W-1:0] big [4];

  lane_in_t lane_d [N_LANE];
  lane_in_t lane_q [N_LANE];

  assign z2_full = az_q * az_q;
  assign xx_full = ax_q * ax_q;
  assign yy_full = ay_q * ay_q;
  assign xy_full = ax_q * ay_q;
  assign fxax_w = focal_x_i * ax_q;
  assign fxay_w = focal_x_i * ay_q;
  assign fyay_w = focal_y_i * ay_q;
  assign fyax_w = focal_y_i * ax_q;

  assign sq_sel[0] = xy_q;
  assign sq_sel[1] = xx_q;
  assign sq_sel[2] = yy_q;
  assign sq_sel[3] = xy_q;
  assign fc_sel[0] = focal_x_i;
  assign fc_sel[1] = focal_x_i;
  assign fc_sel[2] = focal_y_i;
  assign fc_sel[3] = focal_y_i;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      plo_d[k] = fc_sel[k] * sq_sel[k][PT_W-1:0];
      phi_d[k] = fc_sel[k] * sq_sel[k][SQ_W-1:PT_W];
      big[k] = (REM_W'(phi_q[k]) << PT_W) + REM_W'(plo_q[k]);
    end
  end

  always_comb begin
    lane_d[LN_U_TX] = '{num: REM_W'(focal_x_i) << FRAC_BITS, den: DEN_W'(az3_q),
                        add: '0, neg: 1'b0};
    lane_d[LN_U_TZ] = '{num: REM_W'(fxax3_q) << FRAC_BITS, den: z23_q,
                        add: '0, neg: !nx3_q};
    lane_d[LN_U_RX] = '{num: big[0], den: z23_q, add: '0, neg: nx3_q == ny3_q};
    lane_d[LN_U_RY] = '{num: big[1], den: z23_q, add: focal_x_i, neg: 1'b0};
    lane_d[LN_U_RZ] = '{num: REM_W'(fxay3_q), den: DEN_W'(az3_q), add: '0, neg: !ny3_q};
    lane_d[LN_V_TY] = '{num: REM_W'(focal_y_i) << FRAC_BITS, den: DEN_W'(az3_q),
                        add: '0, neg: 1'b0};
    lane_d[LN_V_TZ] = '{num: REM_W'(fyay3_q) << FRAC_BITS, den: z23_q,
                        add: '0, neg: !ny3_q};
    lane_d[LN_V_RX] = '{num: big[2], den: z23_q, add: focal_y_i, neg: 1'b1};
    lane_d[LN_V_RY] = '{num: big[3], den: z23_q, add: '0, neg: nx3_q != ny3_q};
    lane_d[LN_V_RZ] = '{num: REM_W'(fyax3_q), den: DEN_W'(az3_q), add: '0, neg: nx3_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_q <= '0;
      f2_q <= '0;
      f3_q <= '0;
      f4_q <= '0;
    end else begin
      f1_q <= '{act: act_i, pos: act_i && (point_z_i > 0)};
      f2_q <= f1_q;
      f3_q <= f2_q;
      f4_q <= f3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ax_q <= abs_pt(point_x_i);
    ay_q <= abs_pt(point_y_i);
    az_q <= abs_pt(point_z_i);
    nx1_q <= point_x_i[PT_W-1];
    ny1_q <= point_y_i[PT_W-1];

    z2_q <= z2_full[DEN_W-1:0];
    xx_q <= xx_full[SQ_W-1:0];
    yy_q <= yy_full[SQ_W-1:0];
    xy_q <= xy_full[SQ_W-1:0];
    fxax_q <= fxax_w;
    fxay_q <= fxay_w;
    fyay_q <= fyay_w;
    fyax_q <= fyax_w;
    az2_q <= az_q;
    nx2_q <= nx1_q;
    ny2_q <= ny1_q;

    for (int k = 0; k < 4; k++) begin
      plo_q[k] <= plo_d[k];
      phi_q[k] <= phi_d[k];
    end
    z23_q <= z2_q;
    az3_q <= az2_q;
    fxax3_q <= fxax_q;
    fxay3_q <= fxay_q;
    fyay3_q <= fyay_q;
    fyax3_q <= fyax_q;
    nx3_q <= nx2_q;
    ny3_q <= ny2_q;

    for (int k = 0; k < N_LANE; k++) begin
      lane_q[k] <= lane_d[k];
    end
  end

  assign flag_o = f4_q;
  always_comb begin
    for (int k = 0; k < N_LANE; k++) begin
      lane_o[k] = lane_q[k];
    end
  end

endmodule

>>> hdl/se3pj_cell.sv
// One restoring-division cell: yields one quotient bit per clock.
module se3pj_cell (
  input  logic                  clk_i,
  input  se3pj_pkg::div_word_t  word_i,
  output se3pj_pkg::div_word_t  word_o
);
  import se3pj_pkg::*;

  div_word_t word_d, word_q;
  logic [REM_W-1:0] ds_n;

  always_comb begin
    ds_n = word_i.ds >> 1;
    word_d = word_i;
    word_d.ds = ds_n;
    if (word_i.rem >= ds_n) begin
      word_d.rem = word_i.rem - ds_n;
      word_d.quo = {word_i.quo[Q_W-2:0], 1'b1};
    end else begin
      word_d.quo = {word_i.quo[Q_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

>>> hdl/se3pj_lane.sv
// One Jacobian entry: overflow check, divider cell chain, rounding, clamp.
module se3pj_lane (
  input  logic                                 clk_i,
  input  logic                                 ok_i,
  input  se3pj_pkg::lane_in_t                  lane_i,
  output logic signed [se3pj_pkg::ENT_W-1:0]   ent_o
);
  import se3pj_pkg::*;

  localparam logic [Q_W:0] POS_LIM = (Q_W+1)'((64'd1 << (ENT_W - 1)) - 64'd1);

  div_word_t head_d, head_q;
  div_word_t chain [Q_W+1];
  logic rnd;
  logic [Q_W:0] sum_d, sum_q;
  logic sat_q, neg_q, ok_q;
  logic [Q_W:0] lim, mag;
  logic over;
  logic [ENT_W-1:0] ent_d, ent_q;

  always_comb begin
    head_d.ok = ok_i;
    head_d.neg = lane_i.neg;
    head_d.add = lane_i.add;
    head_d.ds = {lane_i.den, {Q_W{1'b0}}};
    head_d.sat = lane_i.num >= {lane_i.den, {Q_W{1'b0}}};
    head_d.rem = lane_i.num;
    head_d.quo = '0;
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
  end

  assign chain[0] = head_q;

  for (genvar k = 0; k < Q_W; k++) begin : g_cell
    se3pj_cell u_cell (
      .clk_i  (clk_i),
      .word_i (chain[k]),
      .word_o (chain[k+1])
    );
  end

  assign rnd = {chain[Q_W].rem, 1'b0} >= {1'b0, chain[Q_W].ds};
  assign sum_d = (Q_W+1)'(chain[Q_W].quo) + (Q_W+1)'(rnd) + (Q_W+1)'(chain[Q_W].add);

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    sat_q <= chain[Q_W].sat;
    neg_q <= chain[Q_W].neg;
    ok_q <= chain[Q_W].ok;
  end

  always_comb begin
    lim = neg_q ? (POS_LIM + 1'b1) : POS_LIM;
    over = sat_q || (sum_q > lim);
    mag = over ? lim : sum_q;
    if (!ok_q) begin
      ent_d = '0;
    end else if (neg_q) begin
      ent_d = ~mag[ENT_W-1:0] + 1'b1;
    end else begin
      ent_d = mag[ENT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o = ent_q;

endmodule

>>> hdl/se3_projection_jacobian_unit.sv
// Pipeline: 4 front-end stages, then 43 per-entry divider stages, from start to done_o.
// Throughput: one point per cycle; busy stays low, each entry has its own 40-cell
// quotient chain, one quotient bit per cell.
// Reset: clears the pipeline valid flags and sets both focal lengths to 512.0.
// Results are presented once on done_o; the receiver cannot stall.
module se3_projection_jacobian_unit #(
  parameter int unsigned FRAC_BITS = se3pj_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [se3pj_pkg::PT_W-1:0]     point_x_i,
  input  logic signed [se3pj_pkg::PT_W-1:0]     point_y_i,
  input  logic signed [se3pj_pkg::PT_W-1:0]     point_z_i,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [se3pj_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [se3pj_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  output logic                                  done_o,
  output logic                                  valid_res_o,
  output logic signed [se3pj_pkg::ENT_W-1:0]    j_u_tx_o,
  output logic signed [se3pj_pkg::ENT_W-1:0]    j_u_tz_o,
  output logic signed [se3pj_pkg::ENT_W-1:0]    j_u_rx_o,
  output logic signed [se3pj_pkg::ENT_W-1:0]    j_u_ry_o,
  output logic signed [se3pj_pkg::ENT_W-1:0]    j_u_rz_o,
  output logic signed [se3pj_pkg::ENT_W-1:0]    j_v_ty_o,
  output logic signed [se3pj_pkg::ENT_W-1:0]    j_v_tz_o,
  output logic signed [se3pj_pkg::ENT_W-1:0]    j_v_rx_o,
  output logic signed [se3pj_pkg::ENT_W-1:0]    j_v_ry_o,
  output logic signed [se3pj_pkg::ENT_W-1:0]    j_v_rz_o
);
  import se3pj_pkg::*;
  `include "se3_projection_jacobian_unit_macros.svh"

  logic acc;
  logic cfg_wr;
  logic [FOC_W-1:0] focal_x_q, focal_x_d, focal_y_q, focal_y_d;
  flag_t flg;
  lane_in_t lane_w [N_LANE];
  logic signed [ENT_W-1:0] ent_w [N_LANE];
  logic [LANE_LAT-1:0] act_q, act_d, pos_q, pos_d;

  assign busy = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign acc = start && !busy;
  assign cfg_wr = cfg_valid_i && cfg_ready_o;

  always_comb begin
    focal_x_d = focal_x_q;
    focal_y_d = focal_y_q;
    if (cfg_wr) begin
      case (cfg_index_i)
        REG_FOCAL_X: focal_x_d = cfg_data_i[FOC_W-1:0];
        REG_FOCAL_Y: focal_y_d = cfg_data_i[FOC_W-1:0];
        default: ;
      endcase
    end
  end

  se3pj_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .act_i     (acc),
    .point_x_i (point_x_i),
    .point_y_i (point_y_i),
    .point_z_i (point_z_i),
    .focal_x_i (focal_x_q),
    .focal_y_i (focal_y_q),
    .flag_o    (flg),
    .lane_o    (lane_w)
  );

  for (genvar k = 0; k < N_LANE; k++) begin : g_lane
    se3pj_lane u_lane (
      .clk_i  (clk_i),
      .ok_i   (flg.pos),
      .lane_i (lane_w[k]),
      .ent_o  (ent_w[k])
    );
  end

  assign act_d = {act_q[LANE_LAT-2:0], flg.act};
  assign pos_d = {pos_q[LANE_LAT-2:0], flg.pos};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_x_q <= FOCAL_RST;
      focal_y_q <= FOCAL_RST;
      act_q <= '0;
      pos_q <= '0;
    end else begin
      focal_x_q <= focal_x_d;
      focal_y_q <= focal_y_d;
      act_q <= act_d;
      pos_q <= pos_d;
    end
  end

  assign done_o = act_q[LANE_LAT-1];
  assign valid_res_o = pos_q[LANE_LAT-1];
  assign j_u_tx_o = ent_w[LN_U_TX];
  assign j_u_tz_o = ent_w[LN_U_TZ];
  assign j_u_rx_o = ent_w[LN_U_RX];
  assign j_u_ry_o = ent_w[LN_U_RY];
  assign j_u_rz_o = ent_w[LN_U_RZ];
  assign j_v_ty_o = ent_w[LN_V_TY];
  assign j_v_tz_o = ent_w[LN_V_TZ];
  assign j_v_rx_o = ent_w[LN_V_RX];
  assign j_v_ry_o = ent_w[LN_V_RY];
  assign j_v_rz_o = ent_w[LN_V_RZ];

  `SE3PJ_ASSERT_IMPL(a_valid_needs_done, clk_i, rst_ni, valid_res_o, done_o)
  `SE3PJ_ASSERT_IMPL(a_invalid_zero, clk_i, rst_ni, done_o && !valid_res_o,
    j_u_tx_o == '0 && j_u_ry_o == '0 && j_v_rx_o == '0 && j_v_rz_o == '0)
  `SE3PJ_ASSERT_IMPL(a_sign_fixed, clk_i, rst_ni, done_o,
    !j_u_tx_o[ENT_W-1] && !j_v_ty_o[ENT_W-1] && !j_u_ry_o[ENT_W-1])
  `SE3PJ_ASSERT_NEXT(a_cfg_fx, clk_i, rst_ni, cfg_wr && cfg_index_i == REG_FOCAL_X,
    focal_x_q == $past(cfg_data_i[FOC_W-1:0]))

endmodule
